// ===== rtl/core/utf8_to_codepoint_decoder_defines.svh =====
// assertion macros for the utf8 to code point decoder
// no dependencies; included by u2c_dp, the module that checks its own logic
`ifndef UTF8_TO_CODEPOINT_DECODER_DEFINES_SVH
`define UTF8_TO_CODEPOINT_DECODER_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define U2C_ASSERT_ALWAYS(name, clk, rst_n, cond) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
	else $error("u2c check failed");
`define U2C_ASSERT_IMPLIES(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("u2c check failed");
`else
`define U2C_ASSERT_ALWAYS(name, clk, rst_n, cond)
`define U2C_ASSERT_IMPLIES(name, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/core/u2c_pkg.sv =====
// types, constants and decode functions for the utf8 to code point decoder
// no dependencies; used by u2c_ctrl, u2c_dp and the top level
package u2c_pkg;

	localparam int unsigned BYTE_W = 8;
	localparam int unsigned CP_W   = 21;
	localparam int unsigned LEN_W  = 3;
	localparam int unsigned CNT_W  = 3;
	localparam int unsigned BUF_DEPTH = 4;

	localparam logic [CP_W-1:0] CP_REPLACEMENT = 21'h00FFFD;

	localparam logic [LEN_W-1:0] LEN_BAD  = 3'd0;
	localparam logic [LEN_W-1:0] LEN_ONE  = 3'd1;
	localparam logic [LEN_W-1:0] LEN_TWO  = 3'd2;
	localparam logic [LEN_W-1:0] LEN_THREE = 3'd3;
	localparam logic [LEN_W-1:0] LEN_FOUR = 3'd4;

	typedef struct packed {
		logic [BYTE_W-1:0] in_byte;
		logic              end_of_string;
	} in_beat_t;

	typedef struct packed {
		logic [CP_W-1:0] code_point;
		logic            run_last;
		logic            string_done;
	} out_beat_t;

	typedef struct packed {
		logic use_in;
		logic emit;
		logic run_last;
		logic string_done;
		logic hold;
		logic advance;
		logic clear;
	} u2c_cmd_t;

	typedef struct packed {
		logic emit_ok;
		logic emit_now;
		logic last;
	} u2c_stat_t;

	function automatic logic [LEN_W-1:0] seq_len(input logic [BYTE_W-1:0] b);
		logic [LEN_W-1:0] len;
		len = LEN_BAD;
		if ((b & 8'h80) == 8'h00) begin
			len = LEN_ONE;
		end else if ((b & 8'hE0) == 8'hC0) begin
			len = LEN_TWO;
		end else if ((b & 8'hF0) == 8'hE0) begin
			len = LEN_THREE;
		end else if ((b & 8'hF8) == 8'hF0) begin
			len = LEN_FOUR;
		end
		return len;
	endfunction

	function automatic logic [CP_W-1:0] decode_seq(
		input logic [BYTE_W-1:0] b0,
		input logic [BYTE_W-1:0] b1,
		input logic [BYTE_W-1:0] b2,
		input logic [BYTE_W-1:0] b3,
		input logic [LEN_W-1:0]  len
	);
		logic [CP_W-1:0] cp;
		case (len)
			LEN_ONE:   cp = {13'd0, b0};
			LEN_TWO:   cp = {10'd0, b0[4:0], b1[5:0]};
			LEN_THREE: cp = {5'd0, b0[3:0], b1[5:0], b2[5:0]};
			LEN_FOUR:  cp = {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
			default:   cp = CP_REPLACEMENT;
		endcase
		return cp;
	endfunction

endpackage

// ===== rtl/core/u2c_ctrl.sv =====
// controller for the utf8 decoder: accepts bytes and sequences the string-end flush
// depends on u2c_pkg
module u2c_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                byte_valid,
	input  logic                end_of_string,
	input  u2c_pkg::u2c_stat_t  stat,
	output logic                byte_stall,
	output u2c_pkg::u2c_cmd_t   cmd
);

	localparam logic ST_IDLE  = 1'b0;
	localparam logic ST_FLUSH = 1'b1;

	logic state_q;
	logic state_d;
	logic accept;

	assign byte_stall = (state_q != ST_IDLE) || !stat.emit_ok;
	assign accept     = byte_valid && !byte_stall;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					cmd.use_in = 1'b1;
					if (!end_of_string) begin
						if (stat.emit_now) begin
							cmd.emit     = 1'b1;
							cmd.run_last = 1'b1;
							cmd.clear    = 1'b1;
						end else begin
							cmd.hold = 1'b1;
						end
					end else begin
						cmd.emit = 1'b1;
						if (stat.last) begin
							cmd.run_last    = 1'b1;
							cmd.string_done = 1'b1;
							cmd.clear       = 1'b1;
						end else begin
							cmd.advance = 1'b1;
							state_d     = ST_FLUSH;
						end
					end
				end
			end
			ST_FLUSH: begin
				if (stat.emit_ok) begin
					cmd.emit = 1'b1;
					if (stat.last) begin
						cmd.run_last    = 1'b1;
						cmd.string_done = 1'b1;
						cmd.clear       = 1'b1;
						state_d         = ST_IDLE;
					end else begin
						cmd.advance = 1'b1;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== rtl/core/u2c_dp.sv =====
// datapath for the utf8 decoder: held bytes, decode step and output register
// depends on u2c_pkg and utf8_to_codepoint_decoder_defines.svh
`include "utf8_to_codepoint_decoder_defines.svh"

module u2c_dp (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [u2c_pkg::BYTE_W-1:0]      in_byte,
	input  u2c_pkg::u2c_cmd_t               cmd,
	input  logic                            cp_stall,
	output u2c_pkg::u2c_stat_t              stat,
	output logic                            cp_valid,
	output u2c_pkg::out_beat_t              cp_data
);

	logic [u2c_pkg::BYTE_W-1:0] buf_q   [u2c_pkg::BUF_DEPTH];
	logic [u2c_pkg::BYTE_W-1:0] view    [u2c_pkg::BUF_DEPTH];
	logic [u2c_pkg::BYTE_W-1:0] shifted [u2c_pkg::BUF_DEPTH];
	logic [u2c_pkg::CNT_W-1:0]  count_q;
	logic [u2c_pkg::CNT_W-1:0]  n;
	logic [1:0]                 k_q;
	logic [u2c_pkg::LEN_W-1:0]  len;
	logic [u2c_pkg::LEN_W-1:0]  adv;
	logic                       fit;
	logic [u2c_pkg::CP_W-1:0]   cp;
	logic                       out_valid_q;
	u2c_pkg::out_beat_t         out_q;

	// bytes seen by the decode step: held bytes plus the incoming one when taken
	always_comb begin
		for (int j = 0; j < u2c_pkg::BUF_DEPTH; j++) begin
			view[j] = buf_q[j];
		end
		n = count_q;
		if (cmd.use_in) begin
			view[count_q[1:0]] = in_byte;
			n = count_q + 3'd1;
		end
	end

	assign len = u2c_pkg::seq_len(view[0]);
	assign fit = (len != u2c_pkg::LEN_BAD) && (len <= n);
	assign cp  = fit ? u2c_pkg::decode_seq(view[0], view[1], view[2], view[3], len)
	                 : u2c_pkg::CP_REPLACEMENT;
	assign adv = fit ? len : u2c_pkg::LEN_ONE;

	assign stat.emit_ok  = !out_valid_q || !cp_stall;
	assign stat.emit_now = (len == u2c_pkg::LEN_BAD) || (len <= n);
	assign stat.last     = (adv >= n) || (k_q == 2'd2);

	// drop the bytes just consumed
	always_comb begin
		for (int j = 0; j < u2c_pkg::BUF_DEPTH; j++) begin
			shifted[j] = view[j];
		end
		case (adv)
			3'd1: begin
				shifted[0] = view[1];
				shifted[1] = view[2];
				shifted[2] = view[3];
			end
			3'd2: begin
				shifted[0] = view[2];
				shifted[1] = view[3];
			end
			3'd3: begin
				shifted[0] = view[3];
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.hold) begin
			buf_q <= view;
		end else if (cmd.advance) begin
			buf_q <= shifted;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			k_q     <= '0;
		end else if (cmd.clear) begin
			count_q <= '0;
			k_q     <= '0;
		end else if (cmd.hold) begin
			count_q <= n;
		end else if (cmd.advance) begin
			count_q <= n - adv;
			k_q     <= k_q + 2'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (!cp_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_q.code_point  <= cp;
			out_q.run_last    <= cmd.run_last;
			out_q.string_done <= cmd.string_done;
		end
	end

	assign cp_valid = out_valid_q;
	assign cp_data  = out_q;

	`U2C_ASSERT_IMPLIES(a_emit_room, clk, arst_n, cmd.emit, stat.emit_ok)
	`U2C_ASSERT_IMPLIES(a_hold_room, clk, arst_n, cmd.hold, count_q < 3'd3)
	`U2C_ASSERT_IMPLIES(a_advance_not_last, clk, arst_n, cmd.advance, !stat.last && cmd.emit)
	`U2C_ASSERT_ALWAYS(a_flush_bound, clk, arst_n, (k_q != 2'd3) && (count_q <= 3'd4))

endmodule

// ===== rtl/core/utf8_to_codepoint_decoder.sv =====
// utf8 byte stream to code point decoder, top level; depends on u2c_pkg, u2c_ctrl, u2c_dp
// one byte accepted per cycle unless byte_stall (output held or flush); a result appears in
// the output register in the cycle after the byte that completes it. a string end with more
// than one result holds off input until each further result (up to two) is emitted by the one decode step.
// reset (arst_n low, asynchronous) empties the held sequence and the output register.
module utf8_to_codepoint_decoder (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                byte_valid,
	output logic                byte_stall,
	input  u2c_pkg::in_beat_t   byte_data,
	output logic                cp_valid,
	input  logic                cp_stall,
	output u2c_pkg::out_beat_t  cp_data
);

	u2c_pkg::u2c_cmd_t  cmd;
	u2c_pkg::u2c_stat_t stat;

	u2c_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.byte_valid    (byte_valid),
		.end_of_string (byte_data.end_of_string),
		.stat          (stat),
		.byte_stall    (byte_stall),
		.cmd           (cmd)
	);

	u2c_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_byte  (byte_data.in_byte),
		.cmd      (cmd),
		.cp_stall (cp_stall),
		.stat     (stat),
		.cp_valid (cp_valid),
		.cp_data  (cp_data)
	);

endmodule
